// ===== rtl/pbdh_pkg.sv =====
// -----------------------------------------------------------------------------
// pbdh_pkg
// Shared widths, types and constants of the per-position byte/delta histogram.
// -----------------------------------------------------------------------------
package pbdh_pkg;

   localparam int MaxRecord    = 256;
   localparam int ByteBits     = 8;
   localparam int PosBits      = 8;
   localparam int SizeBits     = 9;
   localparam int CountBits    = 24;
   localparam int HistAddrBits = PosBits + ByteBits;
   localparam int FifoDepth    = 4;
   localparam int FifoPtrBits  = 2;
   localparam int FifoLvlBits  = 3;

   typedef logic [ByteBits-1:0]     byte_type;
   typedef logic [PosBits-1:0]      pos_type;
   typedef logic [SizeBits-1:0]     size_type;
   typedef logic [CountBits-1:0]    count_type;
   typedef logic [HistAddrBits-1:0] hist_addr_type;
   typedef logic [FifoPtrBits-1:0]  fifo_ptr_type;
   typedef logic [FifoLvlBits-1:0]  fifo_lvl_type;

   typedef struct packed {
      pos_type   position;
      byte_type  delta_byte;
      logic      delta_valid;
      count_type byte_count;
      count_type delta_count;
   } rsp_item_type;

   localparam size_type  SizeMin  = size_type'(1);
   localparam size_type  SizeMax  = size_type'(MaxRecord);
   localparam count_type CountMax = '1;

endpackage

// ===== rtl/pbdh_if.sv =====
// -----------------------------------------------------------------------------
// pbdh_if
// Valid/ready channels of the histogram block: byte input, result output and
// record size register write.
// -----------------------------------------------------------------------------
interface pbdh_req_if import pbdh_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface pbdh_rsp_if import pbdh_pkg::*; ();
   logic      valid;
   logic      ready;
   pos_type   position;
   byte_type  delta_byte;
   logic      delta_valid;
   count_type byte_count;
   count_type delta_count;

   modport source (output valid, output position, output delta_byte, output delta_valid,
                   output byte_count, output delta_count, input ready);
   modport sink   (input valid, input position, input delta_byte, input delta_valid,
                   input byte_count, input delta_count, output ready);
endinterface

interface pbdh_csr_if import pbdh_pkg::*; ();
   logic     valid;
   logic     ready;
   size_type record_size;

   modport source (output valid, output record_size, input ready);
   modport sink   (input valid, input record_size, output ready);
endinterface

// ===== rtl/positional_byte_delta_histogram.sv =====
// -----------------------------------------------------------------------------
// positional_byte_delta_histogram
// Per-position byte and delta histograms over a record-aligned byte stream.
// -----------------------------------------------------------------------------
// One byte item is taken per clock cycle while queued and in-flight results
// leave room in the output queue; each result passes stage 1 and stage 2 into
// the queue. The rate is set by the single read and single write port of each
// histogram RAM, with write-back forwarding between neighbouring items. After
// reset both 65536-entry histograms are zeroed by a clearing pass, during which
// req_chan.ready stays low; record size writes are taken at any time and
// restart the record framing. A four-entry queue holds results until taken.
// -----------------------------------------------------------------------------
module positional_byte_delta_histogram import pbdh_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   pbdh_req_if.sink        req_chan,
   pbdh_rsp_if.source      rsp_chan,
   pbdh_csr_if.sink        csr_chan
);

   // storage
   byte_type      prev_mem   [MaxRecord];
   count_type     byte_hist_mem  [2**HistAddrBits];
   count_type     delta_hist_mem [2**HistAddrBits];
   rsp_item_type  fifo_mem   [FifoDepth];

   // control and framing
   size_type      record_size_ff;
   pos_type       record_position_ff, record_position_in;
   logic          past_first_ff, past_first_in;
   logic          clear_ff;
   hist_addr_type clear_addr_ff;

   // stage 1
   logic          s1_valid_ff;
   pos_type       s1_pos_ff;
   byte_type      s1_byte_ff;
   logic          s1_dvalid_ff;
   byte_type      prev_rd_ff;
   count_type     byte_rd_ff;

   // stage 2
   logic          s2_valid_ff;
   pos_type       s2_pos_ff;
   byte_type      s2_delta_ff;
   logic          s2_dvalid_ff;
   count_type     s2_bcount_ff;
   count_type     delta_rd_ff;

   // forwarding
   logic          bfwd_valid_ff;
   hist_addr_type bfwd_addr_ff;
   count_type     bfwd_data_ff;
   logic          dfwd_valid_ff;
   hist_addr_type dfwd_addr_ff;
   count_type     dfwd_data_ff;

   // output queue
   fifo_ptr_type  wr_ptr_ff, rd_ptr_ff;
   fifo_lvl_type  fifo_lvl_ff;

   logic          req_fire, rsp_fire, csr_fire;
   size_type      size_eff;
   pos_type       pos_cur;
   logic          last_pos;
   fifo_lvl_type  in_flight;

   hist_addr_type s0_baddr, s1_baddr, s1_daddr, s2_daddr;
   count_type     b_old, b_new, d_old, d_new;
   byte_type      s1_delta;
   logic          bh_we, dh_we;
   hist_addr_type bh_waddr, dh_waddr;
   count_type     bh_wdata, dh_wdata;
   rsp_item_type  push_item;

   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid & csr_chan.ready;

   assign in_flight = fifo_lvl_ff + fifo_lvl_type'(s1_valid_ff) + fifo_lvl_type'(s2_valid_ff);
   assign req_chan.ready = !clear_ff && (in_flight < fifo_lvl_type'(FifoDepth));
   assign req_fire       = req_chan.valid & req_chan.ready;

   assign rsp_chan.valid = (fifo_lvl_ff != '0);
   assign rsp_fire       = rsp_chan.valid & rsp_chan.ready;

   // framing
   always_comb begin
      if (record_size_ff < SizeMin) begin
         size_eff = SizeMin;
      end else if (record_size_ff > SizeMax) begin
         size_eff = SizeMax;
      end else begin
         size_eff = record_size_ff;
      end
      pos_cur  = ({1'b0, record_position_ff} >= size_eff) ? '0 : record_position_ff;
      last_pos = (({1'b0, pos_cur} + size_type'(1)) >= size_eff);
      record_position_in = record_position_ff;
      past_first_in      = past_first_ff;
      if (csr_fire) begin
         record_position_in = '0;
         past_first_in      = 1'b0;
      end else if (req_fire) begin
         record_position_in = last_pos ? '0 : pos_cur + pos_type'(1);
         past_first_in      = past_first_ff | last_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         record_size_ff     <= SizeMin;
         record_position_ff <= '0;
         past_first_ff      <= 1'b0;
      end else begin
         if (csr_fire) begin
            record_size_ff <= csr_chan.record_size;
         end
         record_position_ff <= record_position_in;
         past_first_ff      <= past_first_in;
      end
   end

   // clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + hist_addr_type'(1);
         if (&clear_addr_ff) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // previous record: read old, write new at the same entry
   always_ff @(posedge clock) begin
      prev_rd_ff <= prev_mem[pos_cur];
      if (req_fire) begin
         prev_mem[pos_cur] <= req_chan.data_byte;
      end
   end

   // stage 1 and 2 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff    <= pos_cur;
      s1_byte_ff   <= req_chan.data_byte;
      s1_dvalid_ff <= past_first_ff;
      s2_pos_ff    <= s1_pos_ff;
      s2_delta_ff  <= s1_delta;
      s2_dvalid_ff <= s1_dvalid_ff;
      s2_bcount_ff <= b_new;
   end

   // byte histogram update
   assign s0_baddr = {pos_cur, req_chan.data_byte};
   assign s1_baddr = {s1_pos_ff, s1_byte_ff};
   assign b_old    = (bfwd_valid_ff && bfwd_addr_ff == s1_baddr) ? bfwd_data_ff : byte_rd_ff;
   assign b_new    = (b_old == CountMax) ? b_old : b_old + count_type'(1);

   assign bh_we    = clear_ff | s1_valid_ff;
   assign bh_waddr = clear_ff ? clear_addr_ff : s1_baddr;
   assign bh_wdata = clear_ff ? '0 : b_new;

   always_ff @(posedge clock) begin
      byte_rd_ff <= byte_hist_mem[s0_baddr];
      if (bh_we) begin
         byte_hist_mem[bh_waddr] <= bh_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bfwd_valid_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         bfwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         bfwd_addr_ff <= s1_baddr;
         bfwd_data_ff <= b_new;
      end
   end

   // delta histogram update
   assign s1_delta = s1_byte_ff - prev_rd_ff;
   assign s1_daddr = {s1_pos_ff, s1_delta};
   assign s2_daddr = {s2_pos_ff, s2_delta_ff};
   assign d_old    = (dfwd_valid_ff && dfwd_addr_ff == s2_daddr) ? dfwd_data_ff : delta_rd_ff;
   assign d_new    = (d_old == CountMax) ? d_old : d_old + count_type'(1);

   assign dh_we    = clear_ff | (s2_valid_ff & s2_dvalid_ff);
   assign dh_waddr = clear_ff ? clear_addr_ff : s2_daddr;
   assign dh_wdata = clear_ff ? '0 : d_new;

   always_ff @(posedge clock) begin
      delta_rd_ff <= delta_hist_mem[s1_daddr];
      if (dh_we) begin
         delta_hist_mem[dh_waddr] <= dh_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dfwd_valid_ff <= 1'b0;
      end else if (s2_valid_ff && s2_dvalid_ff) begin
         dfwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_dvalid_ff) begin
         dfwd_addr_ff <= s2_daddr;
         dfwd_data_ff <= d_new;
      end
   end

   // output queue
   always_comb begin
      push_item.position    = s2_pos_ff;
      push_item.delta_byte  = s2_dvalid_ff ? s2_delta_ff : '0;
      push_item.delta_valid = s2_dvalid_ff;
      push_item.byte_count  = s2_bcount_ff;
      push_item.delta_count = s2_dvalid_ff ? d_new : '0;
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         fifo_mem[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_lvl_ff <= '0;
      end else begin
         if (s2_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + fifo_ptr_type'(1);
         end
         if (rsp_fire) begin
            rd_ptr_ff <= rd_ptr_ff + fifo_ptr_type'(1);
         end
         fifo_lvl_ff <= fifo_lvl_ff + fifo_lvl_type'(s2_valid_ff) - fifo_lvl_type'(rsp_fire);
      end
   end

   assign rsp_chan.position    = fifo_mem[rd_ptr_ff].position;
   assign rsp_chan.delta_byte  = fifo_mem[rd_ptr_ff].delta_byte;
   assign rsp_chan.delta_valid = fifo_mem[rd_ptr_ff].delta_valid;
   assign rsp_chan.byte_count  = fifo_mem[rd_ptr_ff].byte_count;
   assign rsp_chan.delta_count = fifo_mem[rd_ptr_ff].delta_count;

endmodule

// ===== sim/tb_top.sv =====
// -----------------------------------------------------------------------------
// tb_top
// Testbench of the per-position byte and delta histogram block.
// -----------------------------------------------------------------------------
// A queue of stream bytes feeds a driver that offers them with random gaps.
// At each accepted byte, a predictor with its own record framing, copy of the
// previous record and histograms works out the result. A monitor takes the
// results under random back-pressure and compares each one field by field with
// the oldest prediction. Record sizes are written between phases while the
// block is idle, the extremes and out-of-range values among them. A long
// receiver hold fills the output queue and stalls the input.
// -----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import pbdh_pkg::*;

   localparam int CycleLimit     = 600000;
   localparam int DrainCycles    = 16;
   localparam int ResetCycles    = 10;
   localparam int LongHoldCycles = 150;
   localparam int LongHoldAfter  = 200;
   localparam int HistDepth      = MaxRecord * 256;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pbdh_req_if req_chan ();
   pbdh_rsp_if rsp_chan ();
   pbdh_csr_if csr_chan ();

   positional_byte_delta_histogram dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   size_type     size_reg;
   int unsigned  frame_pos;
   bit           past_first;
   byte_type     prior_record [MaxRecord];
   count_type    byte_counts  [HistDepth];
   count_type    delta_counts [HistDepth];

   byte_type     stream_bytes [$];
   rsp_item_type predicted_results [$];

   int errors       = 0;
   int results_seen = 0;
   int cycles       = 0;
   bit quiet        = 1'b0;
   bit offer_held   = 1'b0;
   int send_gap     = 0;
   int hold_left    = 0;
   int long_left    = 0;
   bit long_done    = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void predict_histogram_result(input byte_type b);
      int unsigned   span;
      int unsigned   pos;
      hist_addr_type addr;
      rsp_item_type  r;
      span = (size_reg == '0) ? 1 : ((size_reg > SizeMax) ? MaxRecord : int'(size_reg));
      pos  = (frame_pos >= span) ? 0 : frame_pos;
      r    = '0;
      r.position = pos_type'(pos);
      addr = {pos_type'(pos), b};
      if (byte_counts[addr] != CountMax) byte_counts[addr] = byte_counts[addr] + count_type'(1);
      r.byte_count  = byte_counts[addr];
      r.delta_valid = past_first;
      if (past_first) begin
         r.delta_byte = b - prior_record[pos_type'(pos)];
         addr = {pos_type'(pos), r.delta_byte};
         if (delta_counts[addr] != CountMax) begin
            delta_counts[addr] = delta_counts[addr] + count_type'(1);
         end
         r.delta_count = delta_counts[addr];
      end
      prior_record[pos_type'(pos)] = b;
      if (pos + 1 >= span) begin
         frame_pos  = 0;
         past_first = 1'b1;
      end else begin
         frame_pos = pos + 1;
      end
      predicted_results.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // sender: take accepted items, then offer the next at the falling edge
   always @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         predict_histogram_result(req_chan.data_byte);
         void'(stream_bytes.pop_front());
         offer_held = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (!offer_held) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid     <= 1'b0;
            req_chan.data_byte <= byte_type'($urandom);
         end else if (stream_bytes.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 11) == 0) begin
            send_gap = $urandom_range(1, 18) - 1;
            req_chan.valid     <= 1'b0;
            req_chan.data_byte <= byte_type'($urandom);
         end else begin
            req_chan.valid     <= 1'b1;
            req_chan.data_byte <= stream_bytes[0];
            offer_held = 1'b1;
         end
      end
   end

   // receiver: random stalls plus one long hold once enough results have come
   always @(negedge clock) begin
      if (long_left > 0) begin
         long_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!long_done && results_seen >= LongHoldAfter) begin
         long_done = 1'b1;
         long_left = LongHoldCycles - 1;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         hold_left = $urandom_range(1, 18) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_seen++;
         if (predicted_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected item, expected none, actual position %0h byte_count %0h",
                     $time, rsp_chan.position, rsp_chan.byte_count);
         end else begin
            want = predicted_results.pop_front();
            check_field("position", want.position, rsp_chan.position);
            check_field("delta_byte", want.delta_byte, rsp_chan.delta_byte);
            check_field("delta_valid", want.delta_valid, rsp_chan.delta_valid);
            check_field("byte_count", want.byte_count, rsp_chan.byte_count);
            check_field("delta_count", want.delta_count, rsp_chan.delta_count);
         end
      end
   end

   initial begin
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   task automatic wait_drained();
      @(posedge clock);
      while (stream_bytes.size() != 0 || predicted_results.size() != 0 || offer_held)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_record_size(input size_type value);
      @(negedge clock);
      csr_chan.valid       <= 1'b1;
      csr_chan.record_size <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      size_reg   = value;
      frame_pos  = 0;
      past_first = 1'b0;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic send_directed(input byte_type list []);
      foreach (list[k]) stream_bytes.push_back(list[k]);
      wait_drained();
   endtask

   task automatic run_random_phase(input size_type value, input int count);
      int       span;
      int       pos;
      byte_type b;
      byte_type last_seen [MaxRecord];
      write_record_size(value);
      span = (value == '0) ? 1 : ((value > SizeMax) ? MaxRecord : int'(value));
      for (int i = 0; i < count; i++) begin
         pos = i % span;
         case ($urandom_range(0, 7))
            4: begin
               case ($urandom_range(0, 3))
                  0: b = 8'h00;
                  1: b = 8'hFF;
                  2: b = 8'h80;
                  default: b = 8'h7F;
               endcase
            end
            5: b = byte_type'(pos & 3);
            6: b = (i >= span) ? last_seen[pos] : byte_type'($urandom);
            7: b = (i >= span) ? last_seen[pos] + byte_type'($urandom_range(0, 2)) - 8'd1
                               : byte_type'($urandom);
            default: b = byte_type'($urandom);
         endcase
         last_seen[pos] = b;
         stream_bytes.push_back(b);
      end
      wait_drained();
   endtask

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.data_byte   = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.record_size = '0;
      size_reg   = SizeMin;
      frame_pos  = 0;
      past_first = 1'b0;
      foreach (prior_record[k]) prior_record[k] = '0;
      foreach (byte_counts[k]) byte_counts[k] = '0;
      foreach (delta_counts[k]) delta_counts[k] = '0;

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // size one from reset: first record without delta, then wrapping deltas
      send_directed('{8'h00, 8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF});
      write_record_size(size_type'(3));
      send_directed('{8'h10, 8'h20, 8'h30, 8'h10, 8'h21, 8'h2F, 8'h10});
      // restart framing mid-record with a size that acts as one
      write_record_size(size_type'(0));
      send_directed('{8'hAA, 8'hAA, 8'h55});
      write_record_size(size_type'(511));
      send_directed('{8'hFF, 8'h00});

      run_random_phase(size_type'(0), 40);
      run_random_phase(size_type'($urandom_range(2, 8)), 120);
      run_random_phase(SizeMin, 40);
      run_random_phase(size_type'($urandom_range(9, 40)), 150);
      run_random_phase(SizeMax, 300);
      run_random_phase(size_type'(511), 270);
      quiet = 1'b1;
      run_random_phase(size_type'($urandom_range(2, 16)), 230);

      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== positional_byte_delta_histogram.f =====
rtl/pbdh_pkg.sv
rtl/pbdh_if.sv
rtl/positional_byte_delta_histogram.sv
sim/tb_top.sv
